// ----- src/clock_offset_estimator_core_defines.svh -----
// assertion macros for the clock offset estimator checker
`ifndef CLOCK_OFFSET_ESTIMATOR_CORE_DEFINES_SVH
`define CLOCK_OFFSET_ESTIMATOR_CORE_DEFINES_SVH

// same-cycle implication
`define COE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("coe check failed");

// next-cycle implication
`define COE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("coe check failed");

`endif

// ----- src/coe_pkg.sv -----
// shared constants and helpers for the clock offset estimator
package coe_pkg;

   localparam int TIME_W    = 63;
   localparam int VAL_W     = 64;
   localparam int GAIN_W    = 17;
   localparam int RATIO_W   = 4;
   localparam int CSR_IDX_W = 2;
   localparam int DEV_W     = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_LOWPASS_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COV_DECAY     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RTT_RATIO = 2'd2;

   localparam logic [GAIN_W-1:0]  Q16_ONE           = 17'd65536;
   localparam logic [GAIN_W-1:0]  Q16_HALF          = 17'd32768;
   localparam logic [GAIN_W-1:0]  LOWPASS_GAIN_RST  = 17'd52429;
   localparam logic [GAIN_W-1:0]  COV_DECAY_RST     = 17'd64881;
   localparam logic [RATIO_W-1:0] MAX_RTT_RATIO_RST = 4'd3;

   localparam logic [VAL_W-1:0] DEV_LIMIT = 64'h0000_0000_7FFF_FFFF;
   localparam logic [VAL_W-1:0] SAT_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VAL_W-1:0] SAT_MIN   = 64'h8000_0000_0000_0000;

   typedef logic [2:0] cov_idx_type;

   // row of a packed upper-triangle covariance entry
   function automatic logic [1:0] pair_row(input cov_idx_type k);
      logic [1:0] r;
      case (k) inside
         3'd0, 3'd1, 3'd2: r = 2'd0;
         3'd3, 3'd4:       r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   // column of a packed upper-triangle covariance entry
   function automatic logic [1:0] pair_col(input cov_idx_type k);
      logic [1:0] c;
      case (k) inside
         3'd0:       c = 2'd0;
         3'd1, 3'd3: c = 2'd1;
         default:    c = 2'd2;
      endcase
      return c;
   endfunction

   function automatic logic [GAIN_W-1:0] sat_gain(input logic [GAIN_W-1:0] g);
      return (g > Q16_ONE) ? Q16_ONE : g;
   endfunction

endpackage

// ----- src/clock_offset_estimator_core.sv -----
// clock offset estimator: sequencer around one shared 32x32 multiplier
// One exchange word in, one offset word out. The first exchange after reset goes through the
// FIRST state to DONE, which loads the output register. A later exchange runs three low-pass
// moves and the round trip test; one that the test skips goes straight to DONE, any other
// runs six covariance updates, the asymmetry solve (a restoring divide for the 16-bit
// quotient unless the result is clamped) and the offset moves, all on one shared 32x32
// multiplier and one adder path. DONE waits while an earlier result still waits for
// rsp_ready. Each Q16 move runs setup, two half-word products and a final add.
// The input is not ready until the result is in the output register, which then waits for
// rsp_ready while the next word is taken.
module clock_offset_estimator_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [coe_pkg::TIME_W-1:0]        req_query_time,
   input  logic [coe_pkg::TIME_W-1:0]        req_reply_time,
   input  logic [coe_pkg::TIME_W-1:0]        req_receive_time,
   input  logic signed [coe_pkg::VAL_W-1:0]  req_previous_offset,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [coe_pkg::VAL_W-1:0]  rsp_offset,
   output logic                              rsp_skipped,
   output logic                              rsp_first_sample,
   output logic [coe_pkg::GAIN_W-1:0]        rsp_asymmetry,
   input  logic                              csr_wr_en,
   input  logic [coe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [coe_pkg::GAIN_W-1:0]        csr_wdata
);

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_FIRST   = 5'd1;
   localparam logic [4:0] ST_MV_SET  = 5'd2;
   localparam logic [4:0] ST_MV_HI   = 5'd3;
   localparam logic [4:0] ST_MV_LO   = 5'd4;
   localparam logic [4:0] ST_MV_FIN  = 5'd5;
   localparam logic [4:0] ST_CHK     = 5'd6;
   localparam logic [4:0] ST_CMP     = 5'd7;
   localparam logic [4:0] ST_DEV     = 5'd8;
   localparam logic [4:0] ST_COV_MUL = 5'd9;
   localparam logic [4:0] ST_COV_ADD = 5'd10;
   localparam logic [4:0] ST_SLV0    = 5'd11;
   localparam logic [4:0] ST_SLV1    = 5'd12;
   localparam logic [4:0] ST_SLV2    = 5'd13;
   localparam logic [4:0] ST_SLV3    = 5'd14;
   localparam logic [4:0] ST_DIV     = 5'd15;
   localparam logic [4:0] ST_OFS     = 5'd16;
   localparam logic [4:0] ST_DONE    = 5'd17;

   localparam logic [1:0] OP_FILT  = 2'd0;
   localparam logic [1:0] OP_COV   = 2'd1;
   localparam logic [1:0] OP_ASYM  = 2'd2;
   localparam logic [1:0] OP_BLEND = 2'd3;

   localparam int W  = coe_pkg::VAL_W;
   localparam int GW = coe_pkg::GAIN_W;
   localparam int DW = coe_pkg::DEV_W;

   function automatic logic [W-1:0] quarter(input logic [W-1:0] c);
      logic [W-1:0] adj;
      adj = c + (c[W-1] ? 64'd3 : 64'd0);
      return {{2{adj[W-1]}}, adj[W-1:2]};
   endfunction

   logic [4:0]         state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   coe_pkg::cov_idx_type idx_ff, idx_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [GW-1:0]      gain_ff, gain_in, decay_ff, decay_in;
   logic [3:0]         ratio_ff, ratio_in;
   logic               started_ff, started_in;
   logic [W-1:0]       filt_ff [3];
   logic [W-1:0]       filt_in [3];
   logic [W-1:0]       cov_ff [6];
   logic [W-1:0]       cov_in [6];
   logic [W-1:0]       u_ff [3];
   logic [W-1:0]       u_in [3];
   logic [DW-1:0]      dev_ff [3];
   logic [DW-1:0]      dev_in [3];
   logic [W-1:0]       prev_ff, prev_in, rtt_ff, rtt_in, mean_ff, mean_in, thr_ff, thr_in;
   logic [W-1:0]       mv_a_ff, mv_a_in, mv_m_ff, mv_m_in, acc_ff, acc_in, res_ff, res_in;
   logic               mv_neg_ff, mv_neg_in;
   logic [GW-1:0]      mv_g_ff, mv_g_in;
   logic [W-1:0]       prod_ff, prod_in;
   logic               prod_neg_ff, prod_neg_in;
   logic [W-1:0]       n1_ff, n1_in, n2_ff, n2_in, d1_ff, d1_in, d2_ff, d2_in;
   logic [W-1:0]       n_ff, n_in, d_ff, d_in, rem_ff, rem_in;
   logic [15:0]        quo_ff, quo_in;
   logic [GW-1:0]      asym_ff, asym_in;
   logic [W-1:0]       off_ff, off_in;
   logic               skip_ff, skip_in, first_ff, first_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]       rsp_offset_ff, rsp_offset_in;
   logic               rsp_skipped_ff, rsp_skipped_in, rsp_first_ff, rsp_first_in;
   logic [GW-1:0]      rsp_asym_ff, rsp_asym_in;

   logic [GW-1:0]      gain_sat, decay_sat;
   logic [W-1:0]       src_a, src_b;
   logic [GW-1:0]      src_g;
   logic               src_neg;
   logic [W-1:0]       mv_result;
   logic [DW-1:0]      dev_row, dev_col, dev_row_abs, dev_col_abs;
   logic [31:0]        mul_a, mul_b;
   logic [W-1:0]       mul_p;
   logic [W-1:0]       s_sum, fv_diff, first_v;
   logic signed [68:0] thr_wide;
   logic [W-1:0]       sp;
   logic signed [W:0]  sum65;
   logic [W-1:0]       cov_sat;
   logic [W-1:0]       dev_diff [3];
   logic [W-1:0]       rem2;
   logic [15:0]        quo_next;
   logic [W-1:0]       q0, q1, q2, q4, q5;

   assign gain_sat  = coe_pkg::sat_gain(gain_ff);
   assign decay_sat = coe_pkg::sat_gain(decay_ff);

   always_comb begin
      case (op_ff)
         OP_FILT: begin
            src_a = filt_ff[idx_ff[1:0]];
            src_b = u_ff[idx_ff[1:0]];
            src_g = gain_sat;
         end
         OP_COV: begin
            src_a = '0;
            src_b = cov_ff[idx_ff];
            src_g = decay_sat;
         end
         OP_ASYM: begin
            src_a = u_ff[2];
            src_b = u_ff[0];
            src_g = asym_ff;
         end
         default: begin
            src_a = off_ff;
            src_b = prev_ff;
            src_g = gain_sat;
         end
      endcase
   end

   assign src_neg   = $signed(src_b) < $signed(src_a);
   assign mv_result = mv_neg_ff ? (mv_a_ff - acc_ff) : (mv_a_ff + acc_ff);

   assign dev_row     = dev_ff[coe_pkg::pair_row(idx_ff)];
   assign dev_col     = dev_ff[coe_pkg::pair_col(idx_ff)];
   assign dev_row_abs = dev_row[DW-1] ? (~dev_row + 32'd1) : dev_row;
   assign dev_col_abs = dev_col[DW-1] ? (~dev_col + 32'd1) : dev_col;

   assign mul_a = (state_ff == ST_MV_HI) ? mv_m_ff[63:32] :
                  (state_ff == ST_MV_LO) ? mv_m_ff[31:0] : dev_row_abs;
   assign mul_b = (state_ff == ST_COV_MUL) ? dev_col_abs : {15'd0, mv_g_ff};
   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

   // symmetric first estimate
   assign s_sum   = u_ff[0] + u_ff[2];
   assign fv_diff = u_ff[1] - {1'b0, s_sum[W-1:1]};
   assign first_v = (s_sum[0] && !fv_diff[W-1] && fv_diff != '0) ? fv_diff - 64'd1 : fv_diff;

   assign thr_wide = $signed(mean_ff) * $signed({1'b0, ratio_ff});

   assign sp    = prod_neg_ff ? (~prod_ff + 64'd1) : prod_ff;
   assign sum65 = $signed({res_ff[W-1], res_ff}) + $signed({sp[W-1], sp});
   always_comb begin
      if (sum65 > $signed({1'b0, coe_pkg::SAT_MAX}))
         cov_sat = coe_pkg::SAT_MAX;
      else if (sum65 < -$signed({1'b0, coe_pkg::SAT_MAX}))
         cov_sat = ~coe_pkg::SAT_MAX + 64'd1;
      else
         cov_sat = sum65[W-1:0];
   end

   for (genvar gi = 0; gi < 3; gi++) begin : g_dev
      assign dev_diff[gi] = u_ff[gi] - filt_ff[gi];
   end

   assign q0 = quarter(cov_ff[0]);
   assign q1 = quarter(cov_ff[1]);
   assign q2 = quarter(cov_ff[2]);
   assign q4 = quarter(cov_ff[4]);
   assign q5 = quarter(cov_ff[5]);

   assign rem2     = {rem_ff[W-2:0], 1'b0};
   assign quo_next = {quo_ff[14:0], (rem2 >= d_ff)};

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      gain_in        = gain_ff;
      decay_in       = decay_ff;
      ratio_in       = ratio_ff;
      started_in     = started_ff;
      filt_in        = filt_ff;
      cov_in         = cov_ff;
      u_in           = u_ff;
      dev_in         = dev_ff;
      prev_in        = prev_ff;
      rtt_in         = rtt_ff;
      mean_in        = mean_ff;
      thr_in         = thr_ff;
      mv_a_in        = mv_a_ff;
      mv_m_in        = mv_m_ff;
      mv_neg_in      = mv_neg_ff;
      mv_g_in        = mv_g_ff;
      acc_in         = acc_ff;
      res_in         = res_ff;
      prod_in        = prod_ff;
      prod_neg_in    = prod_neg_ff;
      n1_in          = n1_ff;
      n2_in          = n2_ff;
      d1_in          = d1_ff;
      d2_in          = d2_ff;
      n_in           = n_ff;
      d_in           = d_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      asym_in        = asym_ff;
      off_in         = off_ff;
      skip_in        = skip_ff;
      first_in       = first_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_offset_in  = rsp_offset_ff;
      rsp_skipped_in = rsp_skipped_ff;
      rsp_first_in   = rsp_first_ff;
      rsp_asym_in    = rsp_asym_ff;

      if (rsp_ready)
         rsp_valid_in = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            coe_pkg::CSR_LOWPASS_GAIN:  gain_in  = csr_wdata;
            coe_pkg::CSR_COV_DECAY:     decay_in = csr_wdata;
            coe_pkg::CSR_MAX_RTT_RATIO: ratio_in = csr_wdata[3:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               u_in[0]  = {1'b0, req_query_time};
               u_in[1]  = {1'b0, req_reply_time};
               u_in[2]  = {1'b0, req_receive_time};
               prev_in  = req_previous_offset;
               rtt_in   = {1'b0, req_receive_time} - {1'b0, req_query_time};
               mean_in  = filt_ff[2] - filt_ff[0];
               skip_in  = 1'b0;
               first_in = 1'b0;
               asym_in  = '0;
               if (!started_ff) begin
                  state_in = ST_FIRST;
               end else begin
                  op_in    = OP_FILT;
                  idx_in   = '0;
                  state_in = ST_MV_SET;
               end
            end
         end
         ST_FIRST: begin
            started_in = 1'b1;
            filt_in    = u_ff;
            off_in     = first_v;
            first_in   = 1'b1;
            state_in   = ST_DONE;
         end
         ST_MV_SET: begin
            mv_a_in   = src_a;
            mv_neg_in = src_neg;
            mv_m_in   = src_neg ? (src_a - src_b) : (src_b - src_a);
            mv_g_in   = src_g;
            state_in  = ST_MV_HI;
         end
         ST_MV_HI: begin
            acc_in   = {mul_p[47:0], 16'd0};
            state_in = ST_MV_LO;
         end
         ST_MV_LO: begin
            acc_in   = acc_ff + {16'd0, mul_p[63:16]};
            state_in = ST_MV_FIN;
         end
         ST_MV_FIN: begin
            case (op_ff)
               OP_FILT: begin
                  filt_in[idx_ff[1:0]] = mv_result;
                  if (idx_ff == 3'd2) begin
                     state_in = ST_CHK;
                  end else begin
                     idx_in   = idx_ff + 3'd1;
                     state_in = ST_MV_SET;
                  end
               end
               OP_COV: begin
                  res_in   = mv_result;
                  state_in = ST_COV_MUL;
               end
               OP_ASYM: begin
                  res_in   = mv_result;
                  state_in = ST_OFS;
               end
               default: begin
                  off_in   = mv_result;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_CHK: begin
            if (thr_wide[68:63] == 6'b000000 || thr_wide[68:63] == 6'b111111)
               thr_in = thr_wide[W-1:0];
            else
               thr_in = thr_wide[68] ? coe_pkg::SAT_MIN : coe_pkg::SAT_MAX;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if ($signed(rtt_ff) > $signed(thr_ff)) begin
               off_in   = prev_ff;
               skip_in  = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_DEV;
            end
         end
         ST_DEV: begin
            for (int i = 0; i < 3; i++) begin
               if ($signed(dev_diff[i]) > $signed(coe_pkg::DEV_LIMIT))
                  dev_in[i] = coe_pkg::DEV_LIMIT[DW-1:0];
               else if ($signed(dev_diff[i]) < -$signed(coe_pkg::DEV_LIMIT))
                  dev_in[i] = ~coe_pkg::DEV_LIMIT[DW-1:0] + 32'd1;
               else
                  dev_in[i] = dev_diff[i][DW-1:0];
            end
            op_in    = OP_COV;
            idx_in   = '0;
            state_in = ST_MV_SET;
         end
         ST_COV_MUL: begin
            prod_in     = mul_p;
            prod_neg_in = dev_row[DW-1] ^ dev_col[DW-1];
            state_in    = ST_COV_ADD;
         end
         ST_COV_ADD: begin
            cov_in[idx_ff] = cov_sat;
            if (idx_ff == 3'd5) begin
               state_in = ST_SLV0;
            end else begin
               idx_in   = idx_ff + 3'd1;
               state_in = ST_MV_SET;
            end
         end
         ST_SLV0: begin
            n1_in    = q1 - q2;
            n2_in    = q5 - q4;
            d1_in    = q0 + q5;
            d2_in    = {q2[W-2:0], 1'b0};
            state_in = ST_SLV1;
         end
         ST_SLV1: begin
            n_in     = n1_ff + n2_ff;
            d_in     = d1_ff - d2_ff;
            state_in = ST_SLV2;
         end
         ST_SLV2: begin
            if (d_ff == '0) begin
               asym_in  = coe_pkg::Q16_HALF;
               op_in    = OP_ASYM;
               state_in = ST_MV_SET;
            end else begin
               if (d_ff[W-1]) begin
                  n_in = ~n_ff + 64'd1;
                  d_in = ~d_ff + 64'd1;
               end
               state_in = ST_SLV3;
            end
         end
         ST_SLV3: begin
            if ($signed(n_ff) <= 0) begin
               asym_in  = '0;
               op_in    = OP_ASYM;
               state_in = ST_MV_SET;
            end else if (n_ff >= d_ff) begin
               asym_in  = coe_pkg::Q16_ONE;
               op_in    = OP_ASYM;
               state_in = ST_MV_SET;
            end else begin
               rem_in   = n_ff;
               quo_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = (rem2 >= d_ff) ? (rem2 - d_ff) : rem2;
            quo_in = quo_next;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               asym_in  = {1'b0, quo_next};
               op_in    = OP_ASYM;
               state_in = ST_MV_SET;
            end
         end
         ST_OFS: begin
            off_in = u_ff[1] - res_ff;
            if (prev_ff != '0) begin
               op_in    = OP_BLEND;
               state_in = ST_MV_SET;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_offset_in  = off_ff;
               rsp_skipped_in = skip_ff;
               rsp_first_in   = first_ff;
               rsp_asym_in    = asym_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_FILT;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         gain_ff      <= coe_pkg::LOWPASS_GAIN_RST;
         decay_ff     <= coe_pkg::COV_DECAY_RST;
         ratio_ff     <= coe_pkg::MAX_RTT_RATIO_RST;
         started_ff   <= 1'b0;
         filt_ff      <= '{default: '0};
         cov_ff       <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         gain_ff      <= gain_in;
         decay_ff     <= decay_in;
         ratio_ff     <= ratio_in;
         started_ff   <= started_in;
         filt_ff      <= filt_in;
         cov_ff       <= cov_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff           <= u_in;
      dev_ff         <= dev_in;
      prev_ff        <= prev_in;
      rtt_ff         <= rtt_in;
      mean_ff        <= mean_in;
      thr_ff         <= thr_in;
      mv_a_ff        <= mv_a_in;
      mv_m_ff        <= mv_m_in;
      mv_neg_ff      <= mv_neg_in;
      mv_g_ff        <= mv_g_in;
      acc_ff         <= acc_in;
      res_ff         <= res_in;
      prod_ff        <= prod_in;
      prod_neg_ff    <= prod_neg_in;
      n1_ff          <= n1_in;
      n2_ff          <= n2_in;
      d1_ff          <= d1_in;
      d2_ff          <= d2_in;
      n_ff           <= n_in;
      d_ff           <= d_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      asym_ff        <= asym_in;
      off_ff         <= off_in;
      skip_ff        <= skip_in;
      first_ff       <= first_in;
      rsp_offset_ff  <= rsp_offset_in;
      rsp_skipped_ff <= rsp_skipped_in;
      rsp_first_ff   <= rsp_first_in;
      rsp_asym_ff    <= rsp_asym_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_offset       = rsp_offset_ff;
   assign rsp_skipped      = rsp_skipped_ff;
   assign rsp_first_sample = rsp_first_ff;
   assign rsp_asymmetry    = rsp_asym_ff;

endmodule

// ----- src/coe_checker.sv -----
// port-level checker for the clock offset estimator, bound to the top level
`include "clock_offset_estimator_core_defines.svh"

module coe_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [coe_pkg::VAL_W-1:0]  rsp_offset,
   input logic                              rsp_skipped,
   input logic                              rsp_first_sample,
   input logic [coe_pkg::GAIN_W-1:0]        rsp_asymmetry
);

   // busy after taking a word
   `COE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // a stalled result word holds
   `COE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_offset) && $stable(rsp_asymmetry))

   // asymmetry is only reported by a full update
   `COE_ASSERT_NOW(a_asym_zero, clock, reset, rsp_valid && (rsp_skipped || rsp_first_sample),
                   rsp_asymmetry == '0)

   // flags exclusive and asymmetry within one
   `COE_ASSERT_NOW(a_rsp_range, clock, reset, rsp_valid,
                   !(rsp_skipped && rsp_first_sample) &&
                   (!rsp_asymmetry[16] || rsp_asymmetry[15:0] == 16'd0))

endmodule

bind clock_offset_estimator_core coe_checker u_coe_checker (.*);

// ----- tb/clock_offset_estimator_core_checker.sv -----
// checker for the clock offset estimator: predicts each result word and compares
module clock_offset_estimator_core_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [coe_pkg::TIME_W-1:0]        req_query_time,
   input  logic [coe_pkg::TIME_W-1:0]        req_reply_time,
   input  logic [coe_pkg::TIME_W-1:0]        req_receive_time,
   input  logic signed [coe_pkg::VAL_W-1:0]  req_previous_offset,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [coe_pkg::VAL_W-1:0]  rsp_offset,
   input  logic                              rsp_skipped,
   input  logic                              rsp_first_sample,
   input  logic [coe_pkg::GAIN_W-1:0]        rsp_asymmetry,
   input  logic                              csr_wr_en,
   input  logic [coe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [coe_pkg::GAIN_W-1:0]        csr_wdata,
   output int                                fail_count,
   output int                                pending
);

   typedef struct {
      logic signed [coe_pkg::VAL_W-1:0] offset;
      logic                             skipped;
      logic                             first_sample;
      logic [coe_pkg::GAIN_W-1:0]       asymmetry;
   } estimate_type;

   localparam longint MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint MIN64 = 64'sh8000_0000_0000_0000;
   localparam longint DEVMAX = 64'sd2147483647;

   estimate_type expected_estimates[$];
   logic seeded;
   longint filt[3];
   longint cov[6];
   logic [coe_pkg::GAIN_W-1:0] gain_reg, decay_reg;
   logic [coe_pkg::RATIO_W-1:0] ratio_reg;

   assign pending = expected_estimates.size();

   function automatic logic [63:0] scale_mag(logic [63:0] m, logic [coe_pkg::GAIN_W-1:0] g);
      logic [63:0] g64;
      g64 = {47'b0, g};
      return (m >> 16) * g64 + (((m & 64'hFFFF) * g64) >> 16);
   endfunction

   function automatic longint step_toward(longint a, longint b, logic [coe_pkg::GAIN_W-1:0] g);
      logic [63:0] ua, ub;
      ua = a;
      ub = b;
      if (b >= a) return longint'(ua + scale_mag(ub - ua, g));
      return longint'(ua - scale_mag(ua - ub, g));
   endfunction

   function automatic longint add_sat(longint a, longint b);
      if (b > 0 && a > MAX64 - b) return MAX64;
      if (b < 0 && a < -MAX64 - b) return -MAX64;
      return a + b;
   endfunction

   function automatic longint scale_ratio(longint r, longint m);
      if (r == 0) return 0;
      if (m > MAX64 / r) return MAX64;
      if (m < MIN64 / r) return MIN64;
      return m * r;
   endfunction

   function automatic longint limit_dev(longint v);
      if (v > DEVMAX) return DEVMAX;
      if (v < -DEVMAX) return -DEVMAX;
      return v;
   endfunction

   function automatic logic [coe_pkg::GAIN_W-1:0] asym_solve();
      longint c00, c01, c02, c12, c22, n, d;
      logic [63:0] rem, ud, q;
      c00 = cov[0] / 4;
      c01 = cov[1] / 4;
      c02 = cov[2] / 4;
      c12 = cov[4] / 4;
      c22 = cov[5] / 4;
      n = c01 - c02 - c12 + c22;
      d = c00 - 2 * c02 + c22;
      q = 0;
      if (d == 0) return coe_pkg::Q16_HALF;
      if (d < 0) begin
         d = -d;
         n = -n;
      end
      if (n <= 0) return 0;
      if (n >= d) return coe_pkg::Q16_ONE;
      rem = n;
      ud = d;
      for (int i = 0; i < 16; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= ud) begin
            rem = rem - ud;
            q[0] = 1'b1;
         end
      end
      return q[coe_pkg::GAIN_W-1:0];
   endfunction

   function automatic estimate_type predict_offset(logic [coe_pkg::TIME_W-1:0] qt,
                                                   logic [coe_pkg::TIME_W-1:0] rt,
                                                   logic [coe_pkg::TIME_W-1:0] vt,
                                                   longint prev);
      estimate_type e;
      longint u[3], dv[3];
      longint rtt, mean, ofs, v;
      logic [63:0] s;
      logic [coe_pkg::GAIN_W-1:0] g, dec, x;
      int k;
      g = coe_pkg::sat_gain(gain_reg);
      dec = coe_pkg::sat_gain(decay_reg);
      u[0] = {1'b0, qt};
      u[1] = {1'b0, rt};
      u[2] = {1'b0, vt};
      e.skipped = 0;
      e.first_sample = 0;
      e.asymmetry = 0;
      if (!seeded) begin
         s = u[0] + u[2];
         v = u[1] - longint'(s >> 1);
         if (s[0] && v > 0) v = v - 1;
         seeded = 1;
         for (int i = 0; i < 3; i++) filt[i] = u[i];
         e.offset = v;
         e.first_sample = 1;
         return e;
      end
      rtt = u[2] - u[0];
      mean = filt[2] - filt[0];
      for (int i = 0; i < 3; i++) filt[i] = step_toward(filt[i], u[i], g);
      if (rtt > scale_ratio(longint'({60'b0, ratio_reg}), mean)) begin
         e.offset = prev;
         e.skipped = 1;
         return e;
      end
      for (int i = 0; i < 3; i++) dv[i] = limit_dev(u[i] - filt[i]);
      k = 0;
      for (int i = 0; i < 3; i++) begin
         for (int j = i; j < 3; j++) begin
            cov[k] = add_sat(step_toward(0, cov[k], dec), dv[i] * dv[j]);
            k++;
         end
      end
      x = asym_solve();
      ofs = u[1] - step_toward(u[2], u[0], x);
      if (prev != 0) ofs = step_toward(ofs, prev, g);
      e.offset = ofs;
      e.asymmetry = x;
      return e;
   endfunction

   always @(posedge clock) begin
      estimate_type got, want;
      if (reset) begin
         seeded = 0;
         for (int i = 0; i < 3; i++) filt[i] = 0;
         for (int i = 0; i < 6; i++) cov[i] = 0;
         gain_reg = coe_pkg::LOWPASS_GAIN_RST;
         decay_reg = coe_pkg::COV_DECAY_RST;
         ratio_reg = coe_pkg::MAX_RTT_RATIO_RST;
         expected_estimates.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               coe_pkg::CSR_LOWPASS_GAIN:  gain_reg = csr_wdata;
               coe_pkg::CSR_COV_DECAY:     decay_reg = csr_wdata;
               coe_pkg::CSR_MAX_RTT_RATIO: ratio_reg = csr_wdata[coe_pkg::RATIO_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got.offset = rsp_offset;
            got.skipped = rsp_skipped;
            got.first_sample = rsp_first_sample;
            got.asymmetry = rsp_asymmetry;
            if (expected_estimates.size() == 0) begin
               $display("%0t: unexpected result word offset %0d", $time, rsp_offset);
               fail_count++;
            end else begin
               want = expected_estimates.pop_front();
               if (got.offset !== want.offset) begin
                  $display("%0t: offset expected %0d actual %0d", $time, want.offset, got.offset);
                  fail_count++;
               end
               if (got.skipped !== want.skipped) begin
                  $display("%0t: skipped expected %0d actual %0d", $time, want.skipped,
                           got.skipped);
                  fail_count++;
               end
               if (got.first_sample !== want.first_sample) begin
                  $display("%0t: first_sample expected %0d actual %0d", $time,
                           want.first_sample, got.first_sample);
                  fail_count++;
               end
               if (got.asymmetry !== want.asymmetry) begin
                  $display("%0t: asymmetry expected %0d actual %0d", $time, want.asymmetry,
                           got.asymmetry);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_estimates.push_back(predict_offset(req_query_time, req_reply_time,
                                                        req_receive_time, req_previous_offset));
      end
   end
endmodule

// ----- tb/clock_offset_estimator_core_tb.sv -----
// testbench top for the clock offset estimator: stimulus, watchdog and verdict
module clock_offset_estimator_core_tb;

   localparam int IDLE_LIMIT = 3000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [coe_pkg::TIME_W-1:0] req_query_time = 0;
   logic [coe_pkg::TIME_W-1:0] req_reply_time = 0;
   logic [coe_pkg::TIME_W-1:0] req_receive_time = 0;
   logic signed [coe_pkg::VAL_W-1:0] req_previous_offset = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [coe_pkg::VAL_W-1:0] rsp_offset;
   logic rsp_skipped, rsp_first_sample;
   logic [coe_pkg::GAIN_W-1:0] rsp_asymmetry;
   logic csr_wr_en = 0;
   logic [coe_pkg::CSR_IDX_W-1:0] csr_index = 0;
   logic [coe_pkg::GAIN_W-1:0] csr_wdata = 0;
   int fail_count, pending;
   int max_gap = 4, max_stall = 4, idle_cycles = 0;
   logic [coe_pkg::TIME_W-1:0] base_time = 63'd1000000;
   logic signed [coe_pkg::VAL_W-1:0] skew = 64'sd5000;

   always #4 clock = ~clock;

   clock_offset_estimator_core dut (.*);

   clock_offset_estimator_core_checker chk (.*);

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("clock_offset_estimator_core verification failed");
         $finish;
      end
   end

   initial begin
      int w;
      @(negedge reset);
      forever begin
         w = $urandom_range(0, max_stall);
         if (w > 0) begin
            rsp_ready <= 0;
            repeat (w) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic send_word(logic [coe_pkg::TIME_W-1:0] qt, logic [coe_pkg::TIME_W-1:0] rt,
                            logic [coe_pkg::TIME_W-1:0] vt,
                            logic signed [coe_pkg::VAL_W-1:0] prev);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_query_time <= qt;
      req_reply_time <= rt;
      req_receive_time <= vt;
      req_previous_offset <= prev;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic csr_write(logic [coe_pkg::CSR_IDX_W-1:0] idx,
                            logic [coe_pkg::GAIN_W-1:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic random_word();
      int kind, rtt;
      logic signed [coe_pkg::VAL_W-1:0] prev;
      logic [coe_pkg::TIME_W-1:0] qt, rt, vt;
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
         0: prev = 0;
         1: prev = rand64();
         default: prev = skew + $signed($urandom_range(0, 2000)) - 1000;
      endcase
      if (kind < 72) begin
         base_time = base_time + $urandom_range(1000, 200000);
         rtt = ($urandom_range(0, 9) == 0) ? $urandom_range(5000, 90000)
                                           : $urandom_range(0, 3000);
         qt = base_time;
         vt = coe_pkg::TIME_W'(base_time + rtt);
         rt = coe_pkg::TIME_W'(base_time + skew + $urandom_range(0, rtt));
         if ($urandom_range(0, 30) == 0) skew = $signed($urandom_range(0, 100000)) - 50000;
      end else if (kind < 86) begin
         qt = coe_pkg::TIME_W'(rand64());
         rt = coe_pkg::TIME_W'(rand64());
         vt = coe_pkg::TIME_W'(rand64());
      end else begin
         qt = base_time + $urandom_range(0, 5000);
         vt = base_time - $urandom_range(0, 5000);
         rt = ($urandom_range(0, 1)) ? coe_pkg::TIME_W'(rand64()) : base_time;
      end
      send_word(qt, rt, vt, prev);
   endtask

   task automatic run_phase(logic [coe_pkg::GAIN_W-1:0] g, logic [coe_pkg::GAIN_W-1:0] d,
                            logic [coe_pkg::GAIN_W-1:0] r, int count);
      csr_write(coe_pkg::CSR_LOWPASS_GAIN, g);
      csr_write(coe_pkg::CSR_COV_DECAY, d);
      csr_write(coe_pkg::CSR_MAX_RTT_RATIO, r);
      csr_wr_en <= 0;
      max_gap = ($urandom_range(0, 2) == 0) ? 0 : 4;
      max_stall = ($urandom_range(0, 2) == 0) ? 0 : 4;
      repeat (count) random_word();
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // first exchange, odd sum with positive offset
      send_word(63'd1, 63'd100, 63'd2, 64'sd0);
      send_word(63'd0, 63'd0, 63'd0, 64'sd0);
      send_word(63'd0, 63'd0, 63'd0, 64'sd0);
      send_word({coe_pkg::TIME_W{1'b1}}, {coe_pkg::TIME_W{1'b1}}, {coe_pkg::TIME_W{1'b1}},
                64'sh7FFF_FFFF_FFFF_FFFF);
      send_word(63'd0, {coe_pkg::TIME_W{1'b1}}, {coe_pkg::TIME_W{1'b1}},
                64'sh8000_0000_0000_0000);
      send_word({coe_pkg::TIME_W{1'b1}}, 63'd0, 63'd0, -64'sd1);
      send_word(63'd5000, 63'd9000, 63'd5100, 64'sd0);
      send_word(63'd5000, 63'd9000, 63'd5100, 64'sd0);
      send_word(63'd5000, 63'd9000, 63'd5100, 64'sd4000);
      send_word(63'd6000, 63'd7000, 63'd5000, 64'sd12);
      send_word(63'd7000, 63'd20000, 63'd7300, -64'sd500);
      send_word(63'd8000, 63'd8100, 63'd8400, 64'sd3);
      send_word(63'd9000, 63'd1, 63'd900000, 64'sd77);
      send_word(63'd10000, 63'd10050, 63'd10100, 64'sd0);
      drain();
      run_phase(17'd0, 17'd0, 17'd0, 130);
      run_phase(coe_pkg::Q16_ONE, coe_pkg::Q16_ONE, 17'd15, 130);
      run_phase(17'h1FFFF, 17'd100000, 17'h1FFF1, 130);
      run_phase(17'd1, 17'd65535, 17'd2, 130);
      run_phase(coe_pkg::GAIN_W'($urandom()), coe_pkg::GAIN_W'($urandom()),
                coe_pkg::GAIN_W'($urandom()), 130);
      run_phase(coe_pkg::LOWPASS_GAIN_RST, coe_pkg::COV_DECAY_RST,
                17'h1FFF0 | coe_pkg::MAX_RTT_RATIO_RST, 130);
      if (fail_count == 0) $display("clock_offset_estimator_core verification clean");
      else $display("clock_offset_estimator_core verification failed");
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+src
src/coe_pkg.sv
src/clock_offset_estimator_core.sv
src/coe_checker.sv
tb/clock_offset_estimator_core_checker.sv
tb/clock_offset_estimator_core_tb.sv
